// ----- design/rx_8n1_octet_deframer_top_assert.svh -----
// assertion macros for the 8n1 octet deframer
`ifndef RX_8N1_OCTET_DEFRAMER_TOP_ASSERT_SVH
`define RX_8N1_OCTET_DEFRAMER_TOP_ASSERT_SVH

// same-cycle implication, checked on i_clk outside reset
`define RX8D_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rx8d assertion failed");

// next-cycle implication, checked on i_clk outside reset
`define RX8D_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rx8d assertion failed");

`endif

// ----- design/rx8d_pkg.sv -----
// shared types and constants for the 8n1 octet deframer
`default_nettype none

package rx8d_pkg;

    // input mode codes
    localparam logic [1:0] MODE_OCTET = 2'd0;
    localparam logic [1:0] MODE_SOF   = 2'd1;
    localparam logic [1:0] MODE_EOF   = 2'd2;

    // result kind codes
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_START = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // bit phase codes: valid data bits held; PH_9 holds none
    localparam logic [3:0] PH_1 = 4'd1;
    localparam logic [3:0] PH_3 = 4'd3;
    localparam logic [3:0] PH_5 = 4'd5;
    localparam logic [3:0] PH_7 = 4'd7;
    localparam logic [3:0] PH_9 = 4'd9;

    localparam logic [7:0] FLUSH_OCTET = 8'hAA;
    localparam int unsigned LEAD_PAD_BITS = 2;

    // output queue depth
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic       last;
    } t_result;

    // results produced by one accepted item
    typedef struct packed {
        logic [1:0] n_push;
        t_result    res0;
        t_result    res1;
    } t_push;

    // queue status toward the top level
    typedef struct packed {
        logic [QAW:0] count;
        logic         room;
    } t_qstat;

endpackage

`default_nettype wire

// ----- design/rx8d_if.sv -----
// valid/ready channel interfaces for items and results
`default_nettype none

interface rx8d_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] octet;

    modport source (output valid, output mode, output octet, input ready);
    modport sink   (input valid, input mode, input octet, output ready);
endinterface

interface rx8d_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output kind, output data_byte, output last, input ready);
    modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

`default_nettype wire

// ----- design/rx8d_core.sv -----
// deframer state and per-octet shift and phase logic
`default_nettype none

module rx8d_core
    import rx8d_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [1:0] i_mode,
    input  wire logic [7:0] i_octet,
    output t_push           o_push
);

    logic [15:0] r_sr, n_sr;
    logic [3:0]  r_ph, n_ph;
    logic        r_fd, n_fd;

    // discard n bits from the front of the pending octet
    function automatic logic [15:0] drop_bits(logic [15:0] sr, int unsigned n);
        logic [7:0] lo;
        lo = sr[7:0] << n;
        return {sr[15:8], lo};
    endfunction

    // move n pending bits into the assembled byte
    function automatic logic [15:0] take_bits(logic [15:0] sr, int unsigned n);
        return sr << n;
    endfunction

    // next state and results for one transfer
    always_comb begin
        logic [15:0] sr;
        logic [7:0]  oct;
        logic        dv;
        logic [7:0]  dbyte;
        n_sr   = r_sr;
        n_ph   = r_ph;
        n_fd   = r_fd;
        o_push = '0;
        dv     = 1'b0;
        dbyte  = '0;
        oct    = (i_mode == MODE_EOF) ? FLUSH_OCTET : i_octet;
        sr     = {r_sr[15:8], oct};
        if (!r_fd) begin
            sr = drop_bits(sr, LEAD_PAD_BITS + 1);
            sr = take_bits(sr, 5);
            n_ph = PH_5;
            n_fd = 1'b1;
        end else begin
            case (r_ph)
                PH_9: begin
                    sr = drop_bits(sr, 1);
                    sr = take_bits(sr, 7);
                    n_ph = PH_7;
                end
                PH_7: begin
                    sr = take_bits(sr, 1);
                    dv = 1'b1;
                    dbyte = sr[15:8];
                    sr = drop_bits(sr, 2);
                    sr = take_bits(sr, 5);
                    n_ph = PH_5;
                end
                PH_5: begin
                    sr = take_bits(sr, 3);
                    dv = 1'b1;
                    dbyte = sr[15:8];
                    sr = drop_bits(sr, 2);
                    sr = take_bits(sr, 3);
                    n_ph = PH_3;
                end
                PH_3: begin
                    sr = take_bits(sr, 5);
                    dv = 1'b1;
                    dbyte = sr[15:8];
                    sr = drop_bits(sr, 2);
                    sr = take_bits(sr, 1);
                    n_ph = PH_1;
                end
                PH_1: begin
                    sr = take_bits(sr, 7);
                    dv = 1'b1;
                    dbyte = sr[15:8];
                    sr = drop_bits(sr, 1);
                    n_ph = PH_9;
                end
                default: begin
                    // stray phase: octet is loaded, nothing else changes
                end
            endcase
        end

        case (i_mode)
            MODE_OCTET: begin
                n_sr = sr;
                if (dv) begin
                    o_push.n_push = 2'd1;
                    o_push.res0   = '{kind: KIND_DATA, data_byte: dbyte, last: 1'b1};
                end
            end
            MODE_SOF: begin
                n_sr = '0;
                n_ph = '0;
                n_fd = 1'b0;
                o_push.n_push = 2'd1;
                o_push.res0   = '{kind: KIND_START, data_byte: 8'd0, last: 1'b1};
            end
            MODE_EOF: begin
                n_sr = sr;
                if (dv) begin
                    o_push.n_push = 2'd2;
                    o_push.res0   = '{kind: KIND_DATA, data_byte: dbyte, last: 1'b0};
                    o_push.res1   = '{kind: KIND_END, data_byte: 8'd0, last: 1'b1};
                end else begin
                    o_push.n_push = 2'd1;
                    o_push.res0   = '{kind: KIND_END, data_byte: 8'd0, last: 1'b1};
                end
            end
            default: begin
                // unused mode: no results, state kept
                n_sr = r_sr;
                n_ph = r_ph;
                n_fd = r_fd;
            end
        endcase

        if (!i_accept) begin
            n_sr   = r_sr;
            n_ph   = r_ph;
            n_fd   = r_fd;
            o_push.n_push = 2'd0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr <= '0;
            r_ph <= '0;
            r_fd <= 1'b0;
        end else begin
            r_sr <= n_sr;
            r_ph <= n_ph;
            r_fd <= n_fd;
        end
    end

endmodule

`default_nettype wire

// ----- design/rx8d_out_fifo.sv -----
// small result queue taking up to two results per cycle
`default_nettype none

module rx8d_out_fifo
    import rx8d_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_push i_push,
    input  wire logic  i_pop_ready,
    output t_result    o_head,
    output logic       o_valid,
    output t_qstat     o_stat
);

    t_result        r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr, n_wptr;
    logic [QAW-1:0] r_rptr, n_rptr;
    logic [QAW:0]   r_count, n_count;
    logic           pop;
    logic [QAW-1:0] wptr_p1;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rptr];
    assign pop     = o_valid && i_pop_ready;
    assign wptr_p1 = r_wptr + QAW'(1);

    // room for the largest burst one transfer can make
    assign o_stat.count = r_count;
    assign o_stat.room  = (r_count <= (QAW + 1)'(QDEPTH - 2));

    // pointer and fill bookkeeping
    always_comb begin
        n_wptr  = r_wptr + QAW'(i_push.n_push);
        n_rptr  = pop ? r_rptr + QAW'(1) : r_rptr;
        n_count = r_count + (QAW + 1)'(i_push.n_push) - (QAW + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push.n_push != 2'd0) begin
            r_mem[r_wptr] <= i_push.res0;
        end
        if (i_push.n_push == 2'd2) begin
            r_mem[wptr_p1] <= i_push.res1;
        end
    end

endmodule

`default_nettype wire

// ----- design/rx_8n1_octet_deframer_top.sv -----
// top level of the 8n1 octet deframer
// results are written into the registered result queue and offered in order behind earlier results
// throughput: one item per cycle while input ready is high; an end of frame that completes a byte
//   gives two results, which leave one at a time through the result queue
// input ready is set by free space in the four-entry result queue
// synchronous active-low reset clears deframer state and empties the queue
`default_nettype none

`include "rx_8n1_octet_deframer_top_assert.svh"

module rx_8n1_octet_deframer_top
    import rx8d_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rx8d_in_if.sink    i_in,
    rx8d_out_if.source o_out
);

    t_push   push;
    t_result head;
    t_qstat  qstat;
    logic    head_valid;
    logic    accept;

    assign i_in.ready = qstat.room;
    assign accept     = i_in.valid && i_in.ready;

    // per-octet deframing
    rx8d_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_mode   (i_in.mode),
        .i_octet  (i_in.octet),
        .o_push   (push)
    );

    // result queue
    rx8d_out_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_pop_ready (o_out.ready),
        .o_head      (head),
        .o_valid     (head_valid),
        .o_stat      (qstat)
    );

    // result channel
    assign o_out.valid     = head_valid;
    assign o_out.kind      = head.kind;
    assign o_out.data_byte = head.data_byte;
    assign o_out.last      = head.last;

    // checks
    `RX8D_ASSERT_NOW(a_count_bound, 1'b1, qstat.count <= (QAW + 1)'(QDEPTH))
    `RX8D_ASSERT_NOW(a_valid_count, 1'b1, o_out.valid == (qstat.count != '0))
    `RX8D_ASSERT_NEXT(a_sof_result, accept && (i_in.mode == MODE_SOF), o_out.valid)
    `RX8D_ASSERT_NOW(a_ready_full, !i_in.ready, qstat.count > (QAW + 1)'(QDEPTH - 2))

endmodule

`default_nettype wire
